>>> design/knnsd_pkg.sv
// Shared types, widths and constants of the k-nearest-neighbor classifier.
`default_nettype none

package knnsd_pkg;

  // Fixed field and register widths
  localparam int PIXEL_W = 8;
  localparam int LABEL_W = 4;
  localparam int DIST_W  = 27;
  localparam int SQ_W    = 16;
  localparam int K_W     = 5;
  localparam int LEN_W   = 11;
  localparam int CNT_W   = 5;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Parameter defaults
  localparam int VECTOR_MAX_DEF  = 1024;
  localparam int K_MAX_DEF       = 16;
  localparam int CLASS_COUNT_DEF = 10;

  // Register reset values
  localparam logic [K_W-1:0]   K_RESET   = 5'd1;
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd784;

  // Register indexes
  localparam logic REG_K_NEIGHBORS   = 1'b0;
  localparam logic REG_VECTOR_LENGTH = 1'b1;

  // Request codes
  typedef enum logic [1:0] {
    ACT_LOAD     = 2'd0,
    ACT_TRAIN    = 2'd1,
    ACT_CLASSIFY = 2'd2
  } action_t;

  // One slot of the sorted list, also the insert request
  typedef struct packed {
    logic               valid;
    logic [DIST_W-1:0]  distance;
    logic [LABEL_W-1:0] label;
  } entry_t;

  // Pixel request into the distance pipeline
  typedef struct packed {
    logic               load;
    logic               train;
    logic [PIXEL_W-1:0] pixel;
    logic [LABEL_W-1:0] label;
  } pix_req_t;

  // Classify sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SCAN,
    ST_PICK,
    ST_DONE
  } vote_state_t;

endpackage

`default_nettype wire

>>> design/knnsd_dist.sv
// Query store, squared-difference pipeline and distance accumulator.
`default_nettype none

module knnsd_dist #(
  parameter int VECTOR_MAX  = knnsd_pkg::VECTOR_MAX_DEF,
  parameter int CLASS_COUNT = knnsd_pkg::CLASS_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  knnsd_pkg::pix_req_t             req,
  input  logic [knnsd_pkg::LEN_W-1:0]     len_reg,
  output knnsd_pkg::entry_t               ins,
  output logic                            idle
);
  import knnsd_pkg::*;

  localparam int IW    = $clog2(VECTOR_MAX);
  localparam int LW    = $clog2(VECTOR_MAX + 1);
  localparam int CMP_W = (LW > LEN_W) ? LW : LEN_W;

  logic [PIXEL_W-1:0] qmem [VECTOR_MAX];

  logic [IW-1:0]      fill_idx;
  logic [IW-1:0]      train_idx;
  logic [CMP_W-1:0]   eff_len;
  logic [IW-1:0]      wr_idx;
  logic [IW-1:0]      fill_idx_next;
  logic [IW-1:0]      rd_idx;
  logic               rd_last;
  logic [IW-1:0]      train_idx_next;
  logic [LABEL_W-1:0] sat_label;

  logic               s1_valid;
  logic               s1_last;
  logic [PIXEL_W-1:0] s1_q;
  logic [PIXEL_W-1:0] s1_pixel;
  logic [LABEL_W-1:0] s1_label;

  logic               s2_valid;
  logic               s2_last;
  logic [SQ_W-1:0]    s2_sq;
  logic [LABEL_W-1:0] s2_label;

  logic [PIXEL_W-1:0] diff;
  logic [SQ_W-1:0]    sq_next;
  logic [DIST_W-1:0]  acc;
  logic [DIST_W:0]    sum;
  logic [DIST_W-1:0]  acc_sat;

  // Effective vector length: zero acts as one, clamp to the store depth
  always_comb begin
    if (len_reg == '0) begin
      eff_len = CMP_W'(1);
    end else if (CMP_W'(len_reg) > CMP_W'(VECTOR_MAX)) begin
      eff_len = CMP_W'(VECTOR_MAX);
    end else begin
      eff_len = CMP_W'(len_reg);
    end
  end

  // Query fill index, wraps at the end of the vector
  always_comb begin
    wr_idx = (CMP_W'(fill_idx) >= eff_len) ? '0 : fill_idx;
    fill_idx_next = ((CMP_W'(wr_idx) + CMP_W'(1)) >= eff_len) ? '0 : wr_idx + IW'(1);
  end

  // Training index, clamped if the length shrank mid-vector
  always_comb begin
    rd_idx = (CMP_W'(train_idx) >= eff_len) ? IW'(eff_len - CMP_W'(1)) : train_idx;
    rd_last = (CMP_W'(rd_idx) + CMP_W'(1)) >= eff_len;
    train_idx_next = rd_last ? '0 : rd_idx + IW'(1);
    sat_label = ({1'b0, req.label} >= (LABEL_W + 1)'(CLASS_COUNT)) ?
                LABEL_W'(CLASS_COUNT - 1) : req.label;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_idx  <= '0;
      train_idx <= '0;
    end else begin
      if (req.load) begin
        fill_idx <= fill_idx_next;
      end
      if (req.train) begin
        train_idx <= train_idx_next;
      end
    end
  end

  // Query store: one write, one registered read
  always_ff @(posedge clk) begin
    if (req.load) begin
      qmem[wr_idx] <= req.pixel;
    end
    if (req.train) begin
      s1_q <= qmem[rd_idx];
    end
  end

  // Stage 1: carry pixel alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req.train;
    end
    if (req.train) begin
      s1_last  <= rd_last;
      s1_pixel <= req.pixel;
      s1_label <= sat_label;
    end
  end

  // Stage 2: absolute difference squared
  always_comb begin
    diff    = (s1_q > s1_pixel) ? s1_q - s1_pixel : s1_pixel - s1_q;
    sq_next = SQ_W'(diff) * SQ_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    if (s1_valid) begin
      s2_last  <= s1_last;
      s2_sq    <= sq_next;
      s2_label <= s1_label;
    end
  end

  // Stage 3: saturating accumulate, insert request at the last pixel
  always_comb begin
    sum     = {1'b0, acc} + (DIST_W + 1)'(s2_sq);
    acc_sat = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      ins.valid <= 1'b0;
    end else begin
      ins.valid <= s2_valid && s2_last;
      if (s2_valid) begin
        acc <= s2_last ? '0 : acc_sat;
      end
    end
    ins.distance <= acc_sat;
    ins.label    <= s2_label;
  end

  assign idle = !s1_valid && !s2_valid && !ins.valid;

`ifndef SYNTHESIS
  a_ins_from_last: assert property (@(posedge clk) disable iff (rst)
    ins.valid |-> $past(s2_valid && s2_last))
    else $error("insert request without a last pixel");
`endif

endmodule

`default_nettype wire

>>> design/knnsd_cell.sv
// One slot of the sorted neighbor chain: ordered insert and scan shift.
`default_nettype none

module knnsd_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              scan,
  input  knnsd_pkg::entry_t ins,
  input  knnsd_pkg::entry_t prev,
  input  logic              prev_beats,
  input  knnsd_pkg::entry_t next,
  output knnsd_pkg::entry_t cur,
  output logic              beats
);
  import knnsd_pkg::*;

  entry_t slot;

  // Held entry ranks ahead of the new one (earlier arrival wins ties)
  assign beats = slot.valid && (slot.distance <= ins.distance);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (scan) begin
      slot <= next;
    end else if (ins.valid && !beats) begin
      // first losing slot takes the new entry, the rest shift down
      slot <= prev_beats ? ins : prev;
    end
  end

  assign cur = slot;

endmodule

`default_nettype wire

>>> design/knnsd_vote.sv
// Classify sequencer: scans the chain head, counts votes, picks the class.
`default_nettype none

module knnsd_vote #(
  parameter int K_MAX       = knnsd_pkg::K_MAX_DEF,
  parameter int CLASS_COUNT = knnsd_pkg::CLASS_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [knnsd_pkg::LABEL_W-1:0]   truth,
  input  logic                            drained,
  input  logic [knnsd_pkg::K_W-1:0]       k_reg,
  input  knnsd_pkg::entry_t               head,
  output logic                            scan,
  output logic                            busy,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [knnsd_pkg::LABEL_W-1:0]   predicted_class,
  output logic [knnsd_pkg::CNT_W-1:0]     vote_count,
  output logic                            matches_truth,
  output logic [knnsd_pkg::CNT_W-1:0]     neighbours_used
);
  import knnsd_pkg::*;

  localparam int VW = $clog2(K_MAX + 1);
  localparam int KC = (VW > K_W) ? VW : K_W;
  localparam int JW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CW = $clog2(CLASS_COUNT);

  vote_state_t        state;
  vote_state_t        state_next;
  logic               load;
  logic [KC-1:0]      eff_k;
  logic               hit;
  logic               last_j;
  logic               last_c;

  logic [LABEL_W-1:0] truth_q;
  logic [JW-1:0]      j;
  logic [VW-1:0]      used;
  logic [VW-1:0]      votes [CLASS_COUNT];
  logic [CW-1:0]      cidx;
  logic [LABEL_W-1:0] best;
  logic [VW-1:0]      best_v;

  // Effective k: zero acts as one, clamp to chain length
  always_comb begin
    if (k_reg == '0) begin
      eff_k = KC'(1);
    end else if (KC'(k_reg) > KC'(K_MAX)) begin
      eff_k = KC'(K_MAX);
    end else begin
      eff_k = KC'(k_reg);
    end
  end

  assign hit    = head.valid && (KC'(j) < eff_k);
  assign last_j = KC'(j) == KC'(K_MAX - 1);
  assign last_c = cidx == CW'(CLASS_COUNT - 1);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and controls
  always_comb begin
    state_next = state;
    scan       = 1'b0;
    load       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drained) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan = 1'b1;
        if (last_j) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (last_c) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = state != ST_IDLE;

  // Vote counters, one lane per class
  always_ff @(posedge clk) begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (start && state == ST_IDLE) begin
        votes[c] <= '0;
      end else if (scan && hit && head.label == LABEL_W'(c)) begin
        votes[c] <= votes[c] + VW'(1);
      end
    end
  end

  // Scan and pick counters
  always_ff @(posedge clk) begin
    if (start && state == ST_IDLE) begin
      truth_q <= truth;
      j       <= '0;
      used    <= '0;
      cidx    <= '0;
      best    <= '0;
      best_v  <= '0;
    end else if (scan) begin
      j <= last_j ? '0 : j + JW'(1);
      if (hit) begin
        used <= used + VW'(1);
      end
    end else if (state == ST_PICK) begin
      // strict compare keeps the lowest class on ties
      if (votes[cidx] > best_v) begin
        best   <= LABEL_W'(cidx);
        best_v <= votes[cidx];
      end
      cidx <= last_c ? '0 : cidx + CW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      predicted_class <= best;
      vote_count      <= CNT_W'(best_v);
      matches_truth   <= best == truth_q;
      neighbours_used <= CNT_W'(used);
    end
  end

`ifndef SYNTHESIS
  a_chain_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK) |-> !head.valid)
    else $error("neighbor chain not empty after scan");
  a_votes_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (best_v <= used))
    else $error("vote count above neighbors used");
`endif

endmodule

`default_nettype wire

>>> design/knn_squared_distance_classifier_unit.sv
// Top level of the k-nearest-neighbor classifier with squared distance.
// A training vector's distance passes stage 1, stage 2 and the insert register before it enters the sorted chain.
// Throughput: query and training pixels are taken one per cycle while no classify request blocks input.
// A classify request blocks input through pipeline drain, a scan shifting the whole neighbor
// chain out through its head, a one-class-per-cycle vote pick and the result load, which also
// waits while an earlier result is still stalled at the output.
// Reset: k = 1, length = 784, indices and accumulator zero, chain empty; query store kept.
`default_nettype none

module knn_squared_distance_classifier_unit #(
  parameter int VECTOR_MAX  = knnsd_pkg::VECTOR_MAX_DEF,
  parameter int K_MAX       = knnsd_pkg::K_MAX_DEF,
  parameter int CLASS_COUNT = knnsd_pkg::CLASS_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      action,
  input  logic [knnsd_pkg::PIXEL_W-1:0]   pixel,
  input  logic [knnsd_pkg::LABEL_W-1:0]   label,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [knnsd_pkg::LABEL_W-1:0]   predicted_class,
  output logic [knnsd_pkg::CNT_W-1:0]     vote_count,
  output logic                            matches_truth,
  output logic [knnsd_pkg::CNT_W-1:0]     neighbours_used,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [knnsd_pkg::LEN_W-1:0]     cfg_data
);
  import knnsd_pkg::*;

  logic [K_W-1:0]   k_reg;
  logic [LEN_W-1:0] len_reg;
  logic             accept;
  pix_req_t         req;
  logic             start;
  entry_t           ins;
  logic             drained;
  logic             scan;
  logic             busy;
  entry_t           cells [K_MAX];
  logic             beats [K_MAX];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg   <= K_RESET;
      len_reg <= LEN_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_K_NEIGHBORS) begin
        k_reg <= cfg_data[K_W-1:0];
      end else if (cfg_index == REG_VECTOR_LENGTH) begin
        len_reg <= cfg_data;
      end
    end
  end

  // Request decode
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    req.load  = accept && (action == ACT_LOAD);
    req.train = accept && (action == ACT_TRAIN);
    req.pixel = pixel;
    req.label = label;
    start     = accept && (action == ACT_CLASSIFY);
  end

  knnsd_dist #(
    .VECTOR_MAX  (VECTOR_MAX),
    .CLASS_COUNT (CLASS_COUNT)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .len_reg (len_reg),
    .ins     (ins),
    .idle    (drained)
  );

  // Sorted neighbor chain
  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_b;

    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_b = 1'b1;
    end else begin : g_body
      assign prev_e = cells[i-1];
      assign prev_b = beats[i-1];
    end

    if (i == K_MAX - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_link
      assign next_e = cells[i+1];
    end

    knnsd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .scan       (scan),
      .ins        (ins),
      .prev       (prev_e),
      .prev_beats (prev_b),
      .next       (next_e),
      .cur        (cells[i]),
      .beats      (beats[i])
    );
  end

  knnsd_vote #(
    .K_MAX       (K_MAX),
    .CLASS_COUNT (CLASS_COUNT)
  ) u_vote (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .truth           (label),
    .drained         (drained),
    .k_reg           (k_reg),
    .head            (cells[0]),
    .scan            (scan),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .predicted_class (predicted_class),
    .vote_count      (vote_count),
    .matches_truth   (matches_truth),
    .neighbours_used (neighbours_used)
  );

endmodule

`default_nettype wire

>>> sim/tb_knn_squared_distance_classifier_unit.sv
// Self-checking testbench for the k-nearest-neighbor squared-distance classifier unit.
`default_nettype none

module tb_knn_squared_distance_classifier_unit;
  import knnsd_pkg::*;

  localparam int VEC_MAX   = VECTOR_MAX_DEF;
  localparam int KMAX      = K_MAX_DEF;
  localparam int CLASSES   = CLASS_COUNT_DEF;
  localparam int DRAIN_CYC = 40;
  localparam int ITEM_GOAL = 1650;
  localparam int VOTE_GOAL = 24;
  localparam int BIG_LEN   = 32;
  localparam int BIG_ITEMS = 3 * BIG_LEN + 4;

  localparam logic [1:0] ACT_IGNORED = 2'd3;

  // Expected classify result
  typedef struct {
    logic [LABEL_W-1:0] cls;
    logic [CNT_W-1:0]   votes;
    logic               hit;
    logic [CNT_W-1:0]   used;
  } vote_t;

  // Predicts classify results and checks them in arrival order
  class knn_vote_predictor;
    logic [K_W-1:0]     k_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [PIXEL_W-1:0] query_store [VEC_MAX];
    int unsigned        fill_idx;
    int unsigned        train_idx;
    int unsigned        acc;
    int unsigned        best_dist [KMAX];
    logic [LABEL_W-1:0] best_lab [KMAX];
    int unsigned        list_count;
    vote_t              pending_votes [$];
    int unsigned        mismatches;

    function new();
      k_reg      = K_RESET;
      len_reg    = LEN_RESET;
      fill_idx   = 0;
      train_idx  = 0;
      acc        = 0;
      mismatches = 0;
      foreach (query_store[i]) query_store[i] = '0;
      clear_list();
    endfunction

    function void clear_list();
      for (int i = 0; i < KMAX; i++) begin
        best_dist[i] = int'(DIST_MAX);
        best_lab[i]  = '0;
      end
      list_count = 0;
    endfunction

    function int unsigned eff_len();
      if (len_reg == 0) return 1;
      if (len_reg > VEC_MAX) return VEC_MAX;
      return len_reg;
    endfunction

    function int unsigned eff_k();
      if (k_reg == 0) return 1;
      if (k_reg > KMAX) return KMAX;
      return k_reg;
    endfunction

    function void set_register(logic idx, logic [LEN_W-1:0] data);
      if (idx == REG_K_NEIGHBORS) k_reg = data[K_W-1:0];
      else len_reg = data;
    endfunction

    // Sorted insert; equal distances go after the ones already held
    function void insert_entry(int unsigned distance, logic [LABEL_W-1:0] lab);
      int unsigned pos;
      int unsigned i;
      pos = 0;
      while (pos < list_count && best_dist[pos] <= distance) pos++;
      if (pos >= KMAX) return;
      i = (list_count < KMAX) ? list_count : KMAX - 1;
      while (i > pos) begin
        best_dist[i] = best_dist[i-1];
        best_lab[i]  = best_lab[i-1];
        i--;
      end
      best_dist[pos] = distance;
      best_lab[pos]  = lab;
      if (list_count < KMAX) list_count++;
    endfunction

    // Update state for one accepted request
    function void take_request(logic [1:0] act, logic [PIXEL_W-1:0] pix,
                               logic [LABEL_W-1:0] lab);
      int unsigned len;
      int unsigned idx;
      int unsigned q;
      int unsigned d;
      int unsigned sq;
      int unsigned n;
      int unsigned best;
      int unsigned votes [CLASSES];
      vote_t       w;
      len = eff_len();
      case (act)
        ACT_LOAD: begin
          if (fill_idx >= len) fill_idx = 0;
          query_store[fill_idx] = pix;
          fill_idx++;
          if (fill_idx >= len) fill_idx = 0;
        end
        ACT_TRAIN: begin
          idx = train_idx;
          if (idx >= len) idx = len - 1;
          q  = query_store[idx];
          d  = (q > pix) ? q - pix : pix - q;
          sq = d * d;
          if (acc > int'(DIST_MAX) - sq) acc = int'(DIST_MAX);
          else acc += sq;
          idx++;
          if (idx >= len) begin
            insert_entry(acc, (lab >= CLASSES) ? LABEL_W'(CLASSES - 1) : lab);
            acc       = 0;
            train_idx = 0;
          end else begin
            train_idx = idx;
          end
        end
        ACT_CLASSIFY: begin
          n = eff_k();
          if (n > list_count) n = list_count;
          foreach (votes[c]) votes[c] = 0;
          for (int i = 0; i < n; i++) votes[best_lab[i]]++;
          best = 0;
          for (int c = 1; c < CLASSES; c++) if (votes[c] > votes[best]) best = c;
          w.cls   = LABEL_W'(best);
          w.votes = CNT_W'(votes[best]);
          w.hit   = (best == lab);
          w.used  = CNT_W'(n);
          pending_votes = {pending_votes, w};
          clear_list();
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one accepted result with the oldest expectation
    task compare_vote(logic [LABEL_W-1:0] cls, logic [CNT_W-1:0] votes, logic hit,
                      logic [CNT_W-1:0] used);
      vote_t w;
      if (pending_votes.size() == 0) begin
        report_mismatch($sformatf("result class %0d with no request pending", cls));
      end else begin
        w = pending_votes.pop_front();
        if (cls !== w.cls)
          report_mismatch($sformatf("predicted_class got %0d want %0d", cls, w.cls));
        if (votes !== w.votes)
          report_mismatch($sformatf("vote_count got %0d want %0d", votes, w.votes));
        if (hit !== w.hit)
          report_mismatch($sformatf("matches_truth got %0d want %0d", hit, w.hit));
        if (used !== w.used)
          report_mismatch($sformatf("neighbours_used got %0d want %0d", used, w.used));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = '0;
  logic [PIXEL_W-1:0] pixel = '0;
  logic [LABEL_W-1:0] label = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [LABEL_W-1:0] predicted_class;
  logic [CNT_W-1:0]   vote_count;
  logic               matches_truth;
  logic [CNT_W-1:0]   neighbours_used;
  logic               cfg_write = 1'b0;
  logic               cfg_index = 1'b0;
  logic [LEN_W-1:0]   cfg_data = '0;

  knn_vote_predictor sb = new();

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 56;
  int unsigned items_sent    = 0;
  int unsigned votes_asked   = 0;

  knn_squared_distance_classifier_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .pixel           (pixel),
    .label           (label),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .predicted_class (predicted_class),
    .vote_count      (vote_count),
    .matches_truth   (matches_truth),
    .neighbours_used (neighbours_used),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random
  always @(negedge clk) begin
    out_stall = (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.compare_vote(predicted_class, vote_count, matches_truth, neighbours_used);
      if (in_valid && !in_stall) sb.take_request(action, pixel, label);
    end
  end

  // Present one request with a random gap ahead; returns at the falling edge
  task automatic send_request(logic [1:0] act, logic [PIXEL_W-1:0] pix,
                              logic [LABEL_W-1:0] lab);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action   = act;
    pixel    = pix;
    label    = lab;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (act != ACT_IGNORED) items_sent++;
    if (act == ACT_CLASSIFY) votes_asked++;
  endtask

  // Wait until every result is back and the insert pipeline has drained
  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending_votes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_register(logic idx, logic [LEN_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.set_register(idx, data);
  endtask

  function automatic logic [PIXEL_W-1:0] random_pixel();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return PIXEL_W'($urandom_range(255));
    endcase
  endfunction

  // Fill every query entry below the current length
  task automatic load_query_vector();
    for (int i = 0; i < sb.eff_len(); i++) send_request(ACT_LOAD, random_pixel(), 4'($urandom));
  endtask

  // Finish the current training vector; style 0 random, 1 exact copy, 2 within one
  task automatic train_vector(int unsigned style);
    int unsigned        len;
    int unsigned        rem;
    int unsigned        idx;
    logic [PIXEL_W-1:0] q;
    logic [PIXEL_W-1:0] p;
    len = sb.eff_len();
    rem = (sb.train_idx >= len) ? 1 : len - sb.train_idx;
    for (int i = 0; i < rem; i++) begin
      idx = (sb.train_idx >= len) ? len - 1 : sb.train_idx;
      q   = sb.query_store[idx];
      case (style)
        1:       p = q;
        2:       p = q ^ PIXEL_W'($urandom_range(1));
        default: p = random_pixel();
      endcase
      send_request(ACT_TRAIN, p, 4'($urandom));
    end
  endtask

  // Random phase: new settings, a full query, then vote episodes
  task automatic run_phase(bit big);
    logic [K_W-1:0]   k_val;
    logic [LEN_W-1:0] len_val;
    int unsigned      episodes;
    int unsigned      nvec;
    settle();
    case ($urandom_range(5))
      0:       k_val = 5'd0;
      1:       k_val = 5'd1;
      2:       k_val = 5'd16;
      3:       k_val = 5'd31;
      default: k_val = K_W'($urandom_range(KMAX, 1));
    endcase
    if (big) len_val = LEN_W'(BIG_LEN);
    else begin
      case ($urandom_range(9))
        0:       len_val = 11'd0;
        1:       len_val = 11'd1;
        default: len_val = LEN_W'($urandom_range(8, 2));
      endcase
    end
    if ($urandom_range(1)) begin
      write_register(REG_K_NEIGHBORS, {6'($urandom), k_val});
      write_register(REG_VECTOR_LENGTH, len_val);
    end else begin
      write_register(REG_VECTOR_LENGTH, len_val);
      write_register(REG_K_NEIGHBORS, {6'($urandom), k_val});
    end
    load_query_vector();
    episodes = big ? 1 : $urandom_range(3, 1);
    for (int e = 0; e < episodes; e++) begin
      nvec = big ? 2 : $urandom_range(20);
      for (int v = 0; v < nvec; v++) begin
        train_vector($urandom_range(2));
        // occasional noise between vectors
        case ($urandom_range(11))
          0: send_request(ACT_IGNORED, 8'($urandom), 4'($urandom));
          1: send_request(ACT_TRAIN, random_pixel(), 4'($urandom));
          2: send_request(ACT_LOAD, random_pixel(), 4'($urandom));
          default: ;
        endcase
      end
      send_request(ACT_CLASSIFY, 8'($urandom), 4'($urandom_range(15)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty list straight after reset
    send_request(ACT_CLASSIFY, 8'h00, 4'd0);
    send_request(ACT_CLASSIFY, 8'hFF, 4'd5);

    // Short vectors: far vector with oversized label, two equal-distance copies
    settle();
    write_register(REG_K_NEIGHBORS, 11'd3);
    write_register(REG_VECTOR_LENGTH, 11'd4);
    send_request(ACT_LOAD, 8'h00, 4'd0);
    send_request(ACT_LOAD, 8'hFF, 4'd0);
    send_request(ACT_LOAD, 8'hAA, 4'd0);
    send_request(ACT_LOAD, 8'h55, 4'd0);
    send_request(ACT_TRAIN, 8'hFF, 4'd1);
    send_request(ACT_TRAIN, 8'h00, 4'd1);
    send_request(ACT_TRAIN, 8'h55, 4'd1);
    send_request(ACT_TRAIN, 8'hAA, 4'd15);
    for (int c = 2; c <= 3; c++) begin
      send_request(ACT_TRAIN, 8'h00, 4'd0);
      send_request(ACT_TRAIN, 8'hFF, 4'd0);
      send_request(ACT_TRAIN, 8'hAA, 4'd0);
      send_request(ACT_TRAIN, 8'h55, 4'(c));
    end
    send_request(ACT_IGNORED, 8'hFF, 4'hF);
    send_request(ACT_CLASSIFY, 8'h00, 4'd2);

    // Partial vector survives a classify on an empty list
    send_request(ACT_TRAIN, 8'h00, 4'd4);
    send_request(ACT_TRAIN, 8'hFF, 4'd4);
    send_request(ACT_CLASSIFY, 8'h00, 4'd9);

    // Length zero acts as one and cuts the partial vector short
    settle();
    write_register(REG_VECTOR_LENGTH, 11'd0);
    write_register(REG_K_NEIGHBORS, 11'h010);
    send_request(ACT_LOAD, 8'h80, 4'd0);
    send_request(ACT_TRAIN, 8'h7F, 4'd12);
    send_request(ACT_TRAIN, 8'h80, 4'd0);
    send_request(ACT_CLASSIFY, 8'h00, 4'd9);

    // Random phases with shifting idle patterns
    while (items_sent + BIG_ITEMS < ITEM_GOAL || votes_asked < VOTE_GOAL) begin
      if (items_sent < ITEM_GOAL / 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 56;
      end else if (items_sent < 2 * ITEM_GOAL / 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_phase(1'b0);
    end

    // One phase with longer vectors
    run_phase(1'b1);

    in_valid = 1'b0;
    while (sb.pending_votes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_votes.size() == 0) begin
      $display("tb_knn_squared_distance_classifier_unit: clean");
    end else begin
      $display("tb_knn_squared_distance_classifier_unit: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb_knn_squared_distance_classifier_unit: errors");
    $finish;
  end

endmodule

`default_nettype wire
